// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the job queue top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every rising clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== hw/rtl/cpjq_pkg.sv =====
// Package with the operation and status codes and the sequencer states of the job queue.
package cpjq_pkg;
	typedef enum logic [1:0] {
		OP_ADD    = 2'd0,
		OP_TAKE   = 2'd1,
		OP_REMOVE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_APPENDED   = 3'd0,
		ST_UPDATED    = 3'd1,
		ST_DISPATCHED = 3'd2,
		ST_EMPTY      = 3'd3,
		ST_FULL       = 3'd4,
		ST_REMOVED    = 3'd5,
		ST_IGNORED    = 3'd6
	} status_t;

	// SCAN walks the table; COMPACT moves entries down after a take, while a remove compacts during SCAN.
	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_PICK,
		S_COMPACT,
		S_DONE
	} state_t;

	localparam int COUNT_BITS = 6;
endpackage

// ===== hw/rtl/cpjq_if.sv =====
// Valid/ready channel interface carrying one word of payload.
interface cpjq_if #(parameter int W = 8) (input logic clk);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/cpjq_mem.sv =====
// Job slot memory with one write port and one registered read port.
module cpjq_mem #(
	parameter int DEPTH = 32,
	parameter int W     = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);
	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/coalescing_priority_job_queue_unit.sv =====
// Top level of the coalescing priority job queue.
// Input channel in_ch: operation, entry_key, listener_key, upgrade, priority_req
// packed as {operation, entry_key, listener_key, upgrade, priority_req}, MSB first.
// Output channel out_ch: {status, job_entry, job_listener, job_upgrade,
// removed_count, occupancy}, one word for each input word.
// Add, take and remove scan the job memory at most once, one slot a cycle through the
// registered read port; an add stops at a matching slot and a take at the first job
// with priority set. A remove compacts in place during its scan, and a take then
// rewrites the tail behind the picked slot one slot a cycle; the single read port
// of the slot memory paces these passes.
// Clear, a take from an empty table and an add with no listener finish without reading the slot memory.
// One item is in work at a time; ready is high only in the idle state, so the next
// word is taken in the cycle after the result leaves at the earliest.
// Reset empties the table at once; slot contents are not cleared since slots at
// or above the count are never read.
// A stalled receiver holds the block in its done state with the result stable.
module coalescing_priority_job_queue_unit #(
	parameter int QUEUE_DEPTH   = 32,
	parameter int ENTRY_BITS    = 16,
	parameter int LISTENER_BITS = 8
) (
	input logic clk,
	input logic arst_n,
	cpjq_if.sink   in_ch,
	cpjq_if.source out_ch
);
	import cpjq_pkg::*;
	`include "assert_macros.svh"

	localparam int AW  = $clog2(QUEUE_DEPTH);
	localparam int CW  = $clog2(QUEUE_DEPTH + 1);
	localparam int SW  = ENTRY_BITS + LISTENER_BITS + 2;
	localparam int IW  = 2 + ENTRY_BITS + LISTENER_BITS + 2;

	// Slot layout: {entry, listener, upgrade, prio}.
	logic [1:0]               op_q;
	logic [ENTRY_BITS-1:0]    ent_q;
	logic [LISTENER_BITS-1:0] lis_q;
	logic                     upg_q, pri_q;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [CW-1:0] ridx_q;   // address issued this cycle
	logic          rvld_q;   // data for rd_idx_q available
	logic [CW-1:0] rd_idx_q;
	logic [CW-1:0] widx_q;   // compaction write pointer
	logic [CW-1:0] removed_q;
	logic          found_q, hasnu_q;
	logic [CW-1:0] pidx_q, nidx_q;
	logic [SW-1:0] pslot_q, nslot_q, slot0_q;

	logic          we;
	logic [AW-1:0] waddr;
	logic [SW-1:0] wdata;
	logic [SW-1:0] rdata;

	logic [2:0]               o_status_q;
	logic [ENTRY_BITS-1:0]    o_ent_q;
	logic [LISTENER_BITS-1:0] o_lis_q;
	logic                     o_upg_q;
	logic [COUNT_BITS-1:0]    o_rem_q, o_occ_q;

	cpjq_mem #(.DEPTH(QUEUE_DEPTH), .W(SW)) u_mem (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(ridx_q[AW-1:0]), .rdata(rdata)
	);

	wire accept  = in_ch.valid && in_ch.ready;
	wire [ENTRY_BITS-1:0]    r_ent = rdata[SW-1 -: ENTRY_BITS];
	wire [LISTENER_BITS-1:0] r_lis = rdata[LISTENER_BITS+1:2];
	wire r_upg = rdata[1];
	wire r_pri = rdata[0];
	wire match = (r_ent == ent_q) && (r_lis == lis_q) && (r_upg == upg_q);
	wire scan_end = (ridx_q == count_q);
	// Slot that a take removes, valid in the pick state.
	wire [CW-1:0] pick_idx = found_q ? pidx_q : (hasnu_q ? nidx_q : '0);

	assign in_ch.ready = (state_q == S_IDLE);
	assign out_ch.valid = (state_q == S_DONE);
	assign out_ch.data = {o_status_q, o_ent_q, o_lis_q, o_upg_q, o_rem_q, o_occ_q};

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: if (accept) begin
				state_d = S_SCAN;
			end
			S_SCAN: begin
				if (op_q == OP_CLEAR || (op_q == OP_ADD && lis_q == '0)
				    || (op_q == OP_TAKE && count_q == '0)) begin
					state_d = S_DONE;
				end else if (op_q == OP_ADD && rvld_q && match) begin
					state_d = S_DONE;
				end else if (op_q == OP_REMOVE) begin
					if (!rvld_q && scan_end) state_d = S_DONE;
				end else if (!rvld_q && scan_end) begin
					state_d = (op_q == OP_ADD) ? S_DONE : S_PICK;
				end else if (op_q == OP_TAKE && rvld_q && r_pri) begin
					state_d = S_PICK;
				end
			end
			S_PICK:    state_d = S_COMPACT;
			S_COMPACT: if (!rvld_q && scan_end) begin
				state_d = S_DONE;
			end
			S_DONE: if (out_ch.ready) begin
				state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	// Memory writes: append, update, or compaction move.
	always_comb begin
		we    = 1'b0;
		waddr = widx_q[AW-1:0];
		wdata = rdata;
		case (state_q)
			S_SCAN: begin
				if (op_q == OP_ADD && lis_q != '0) begin
					if (rvld_q && match) begin
						we    = 1'b1;
						waddr = rd_idx_q[AW-1:0];
						wdata = {ent_q, lis_q, upg_q, pri_q};
					end else if (!rvld_q && scan_end && count_q < CW'(QUEUE_DEPTH)) begin
						we    = 1'b1;
						waddr = count_q[AW-1:0];
						wdata = {ent_q, lis_q, upg_q, pri_q};
					end
				end else if (op_q == OP_REMOVE && rvld_q && r_lis != lis_q) begin
					we = 1'b1;
				end
			end
			S_COMPACT: if (rvld_q) begin
				we = 1'b1;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			rvld_q   <= 1'b0;
			ridx_q   <= '0;
		end else begin
			state_q <= state_d;
			rvld_q  <= 1'b0;
			case (state_q)
				S_IDLE: if (accept) begin
					ridx_q <= '0;
				end
				S_SCAN: begin
					if (!scan_end && !(op_q == OP_TAKE && rvld_q && r_pri)) begin
						ridx_q <= ridx_q + 1'b1;
						rvld_q <= 1'b1;
					end
					if (state_d == S_DONE) begin
						if (op_q == OP_CLEAR) begin
							count_q <= '0;
						end else if (op_q == OP_ADD && lis_q != '0 && !(rvld_q && match)
						             && count_q < CW'(QUEUE_DEPTH)) begin
							count_q <= count_q + 1'b1;
						end else if (op_q == OP_REMOVE) begin
							count_q <= widx_q + ((rvld_q && r_lis != lis_q) ? 1'b1 : 1'b0);
						end
					end
				end
				S_PICK: begin
					// The compaction pass issues its first read from the slot after the pick.
					ridx_q <= pick_idx + 1'b1;
				end
				S_COMPACT: begin
					if (!scan_end) begin
						ridx_q <= ridx_q + 1'b1;
						rvld_q <= 1'b1;
					end
					if (state_d == S_DONE) count_q <= count_q - 1'b1;
				end
				default: ;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			{op_q, ent_q, lis_q, upg_q, pri_q} <= in_ch.data[IW-1:0];
			widx_q    <= '0;
			removed_q <= '0;
			found_q   <= 1'b0;
			hasnu_q   <= 1'b0;
		end
		rd_idx_q <= ridx_q;
		if (state_q == S_SCAN && rvld_q) begin
			if (rd_idx_q == '0) slot0_q <= rdata;
			if (op_q == OP_TAKE) begin
				if (r_pri) begin
					found_q <= 1'b1;
					pslot_q <= rdata;
					pidx_q  <= rd_idx_q;
				end else if (!r_upg && !hasnu_q) begin
					hasnu_q <= 1'b1;
					nslot_q <= rdata;
					nidx_q  <= rd_idx_q;
				end
			end
			if (op_q == OP_REMOVE) begin
				if (r_lis == lis_q) removed_q <= removed_q + 1'b1;
				else widx_q <= widx_q + 1'b1;
			end
		end
		if (state_q == S_PICK) begin
			if (found_q) begin
				widx_q <= pidx_q; pslot_q <= pslot_q;
			end else if (hasnu_q) begin
				widx_q <= nidx_q; pslot_q <= nslot_q;
			end else begin
				widx_q <= '0; pslot_q <= slot0_q;
			end
		end
		if (state_q == S_COMPACT && rvld_q) widx_q <= widx_q + 1'b1;
	end

	// Result register; loaded when the sequencer enters the done state.
	always_ff @(posedge clk) begin
		if (state_q != S_DONE && state_d == S_DONE) begin
			o_ent_q <= '0; o_lis_q <= '0; o_upg_q <= 1'b0; o_rem_q <= '0;
			case (op_q)
				OP_ADD: begin
					if (lis_q == '0) begin
						o_status_q <= ST_IGNORED;
						o_occ_q    <= COUNT_BITS'(count_q);
					end else if (rvld_q && match) begin
						o_status_q <= ST_UPDATED;
						o_occ_q    <= COUNT_BITS'(count_q);
					end else if (count_q >= CW'(QUEUE_DEPTH)) begin
						o_status_q <= ST_FULL;
						o_occ_q    <= COUNT_BITS'(count_q);
					end else begin
						o_status_q <= ST_APPENDED;
						o_occ_q    <= COUNT_BITS'(count_q + 1'b1);
					end
				end
				OP_TAKE: begin
					if (count_q == '0) begin
						o_status_q <= ST_EMPTY;
						o_occ_q    <= '0;
					end else begin
						o_status_q <= ST_DISPATCHED;
						o_ent_q    <= pslot_q[SW-1 -: ENTRY_BITS];
						o_lis_q    <= pslot_q[LISTENER_BITS+1:2];
						o_upg_q    <= pslot_q[1];
						o_occ_q    <= COUNT_BITS'(count_q - 1'b1);
					end
				end
				OP_REMOVE: begin
					o_status_q <= ST_REMOVED;
					o_rem_q    <= COUNT_BITS'(removed_q
					              + ((rvld_q && r_lis == lis_q) ? 1'b1 : 1'b0));
					o_occ_q    <= COUNT_BITS'(widx_q
					              + ((rvld_q && r_lis != lis_q) ? 1'b1 : 1'b0));
				end
				default: begin
					o_status_q <= ST_REMOVED;
					o_rem_q    <= COUNT_BITS'(count_q);
					o_occ_q    <= '0;
				end
			endcase
		end
	end

	`ASSERT_IMP(a_count_max, clk, arst_n, 1'b1, count_q <= CW'(QUEUE_DEPTH),
		"job count above depth")
	`ASSERT_IMP(a_no_write_idle, clk, arst_n, state_q == S_IDLE, !we,
		"slot write while idle")
	`ASSERT_NEXT(a_hold_out, clk, arst_n, out_ch.valid && !out_ch.ready,
		out_ch.valid && $stable(out_ch.data), "result changed while stalled")
endmodule

// ===== bench/coalescing_priority_job_queue_unit_tb.sv =====
// Self-checking testbench of the coalescing priority job queue with its own table predictor.
module coalescing_priority_job_queue_unit_tb;
	import cpjq_pkg::*;

	localparam int DEPTH = 32;
	localparam int IN_W = 2 + 16 + 8 + 1 + 1;
	localparam int OUT_W = 3 + 16 + 8 + 1 + 6 + 6;

	typedef struct packed {
		op_t         op;
		logic [15:0] entry;
		logic [7:0]  listener;
		logic        upgrade;
		logic        prio;
	} cmd_word_t;

	typedef struct packed {
		status_t     status;
		logic [15:0] entry;
		logic [7:0]  listener;
		logic        upgrade;
		logic [5:0]  removed;
		logic [5:0]  occupancy;
	} reply_word_t;

	typedef struct packed {
		logic [15:0] entry;
		logic [7:0]  listener;
		logic        upgrade;
		logic        prio;
	} job_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cpjq_if #(.W(IN_W)) cmd_ch (.clk(clk));
	cpjq_if #(.W(OUT_W)) reply_ch (.clk(clk));

	coalescing_priority_job_queue_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(cmd_ch),
		.out_ch(reply_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	job_t        table_jobs[$];
	reply_word_t pending_replies[$];
	int          failures = 0;
	int          replies_seen = 0;
	int          words_sent = 0;
	int          hold_off_cycles = 0;
	int          rx_wait = 0;
	bit          stall_enable = 1'b1;
	int          count_taken = 0;
	int          count_full = 0;

	// Applies one command to the shadow table and returns the reply it should produce.
	function automatic reply_word_t predict_reply(cmd_word_t c);
		reply_word_t r;
		int          pick;
		int          n;
		job_t        kept[$];
		r = '0;
		r.status = ST_IGNORED;
		case (c.op)
			OP_ADD: begin
				if (c.listener != 0) begin
					pick = -1;
					foreach (table_jobs[i])
						if (pick < 0 && table_jobs[i].entry == c.entry &&
								table_jobs[i].listener == c.listener &&
								table_jobs[i].upgrade == c.upgrade)
							pick = i;
					if (pick >= 0) begin
						table_jobs[pick].prio = c.prio;
						r.status = ST_UPDATED;
					end else if (table_jobs.size() >= DEPTH) begin
						r.status = ST_FULL;
					end else begin
						table_jobs.insert(table_jobs.size(),
							job_t'({c.entry, c.listener, c.upgrade, c.prio}));
						r.status = ST_APPENDED;
					end
				end
			end
			OP_TAKE: begin
				if (table_jobs.size() == 0) begin
					r.status = ST_EMPTY;
				end else begin
					pick = -1;
					foreach (table_jobs[i])
						if (pick < 0 && table_jobs[i].prio) pick = i;
					foreach (table_jobs[i])
						if (pick < 0 && !table_jobs[i].upgrade) pick = i;
					if (pick < 0) pick = 0;
					r.entry = table_jobs[pick].entry;
					r.listener = table_jobs[pick].listener;
					r.upgrade = table_jobs[pick].upgrade;
					table_jobs.delete(pick);
					r.status = ST_DISPATCHED;
				end
			end
			OP_REMOVE: begin
				n = 0;
				foreach (table_jobs[i])
					if (table_jobs[i].listener == c.listener) n++;
					else kept.insert(kept.size(), table_jobs[i]);
				table_jobs = kept;
				r.removed = 6'(n);
				r.status = ST_REMOVED;
			end
			default: begin
				r.removed = 6'(table_jobs.size());
				table_jobs.delete();
				r.status = ST_REMOVED;
			end
		endcase
		r.occupancy = 6'(table_jobs.size());
		return r;
	endfunction

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		reply_ch.ready = 1'b0;
	end

	// Valid stays high after a word is taken; the next call either offers a new
	// word in the same step or drops valid for its gap.
	task automatic send_word(cmd_word_t c, int gap);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.data <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		pending_replies.insert(pending_replies.size(), predict_reply(c));
		words_sent++;
	endtask

	task automatic send_cmd(op_t op, logic [15:0] e, logic [7:0] l, logic u, logic p,
			int gap = 0);
		cmd_word_t c;
		c.op = op;
		c.entry = e;
		c.listener = l;
		c.upgrade = u;
		c.prio = p;
		send_word(c, gap);
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Receiver: with stalls enabled, after each word it waits a random number of cycles, plus a long
	// hold-off when requested.
	always @(posedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			reply_ch.ready <= 1'b0;
		end else if (!stall_enable) begin
			reply_ch.ready <= 1'b1;
		end else if (reply_ch.valid && reply_ch.ready) begin
			int w;
			w = $urandom_range(0, 8);
			rx_wait <= (w > 0) ? w - 1 : 0;
			reply_ch.ready <= (w == 0);
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			reply_ch.ready <= 1'b0;
		end else begin
			reply_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		reply_word_t got;
		reply_word_t want;
		if (arst_n && reply_ch.valid && reply_ch.ready) begin
			got = reply_ch.data;
			replies_seen++;
			if (pending_replies.size() == 0) begin
				failures++;
				$display("%0t unexpected word %h", $time, got);
			end else begin
				want = pending_replies.pop_front();
				if (got.status == ST_DISPATCHED) count_taken++;
				if (got.status == ST_FULL) count_full++;
				if (got.status !== want.status) begin
					failures++;
					$display("%0t status exp %0d got %0d", $time, want.status, got.status);
				end
				if (got.entry !== want.entry) begin
					failures++;
					$display("%0t job_entry exp %h got %h", $time, want.entry, got.entry);
				end
				if (got.listener !== want.listener) begin
					failures++;
					$display("%0t job_listener exp %h got %h", $time, want.listener,
						got.listener);
				end
				if (got.upgrade !== want.upgrade) begin
					failures++;
					$display("%0t job_upgrade exp %b got %b", $time, want.upgrade,
						got.upgrade);
				end
				if (got.removed !== want.removed) begin
					failures++;
					$display("%0t removed_count exp %0d got %0d", $time, want.removed,
						got.removed);
				end
				if (got.occupancy !== want.occupancy) begin
					failures++;
					$display("%0t occupancy exp %0d got %0d", $time, want.occupancy,
						got.occupancy);
				end
			end
		end
	end

	task automatic test_directed_cases();
		send_cmd(OP_TAKE, 16'h0, 8'h0, 1'b0, 1'b0);
		send_cmd(OP_ADD, 16'h1234, 8'h00, 1'b0, 1'b1);
		send_cmd(OP_ADD, 16'hFFFF, 8'hFF, 1'b1, 1'b0);
		send_cmd(OP_ADD, 16'h0000, 8'h01, 1'b0, 1'b0);
		send_cmd(OP_ADD, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		send_cmd(OP_ADD, 16'hFFFF, 8'hFF, 1'b0, 1'b0);
		send_cmd(OP_ADD, 16'hAAAA, 8'h55, 1'b1, 1'b0);
		send_cmd(OP_TAKE, 16'h0, 8'h0, 1'b0, 1'b0);
		send_cmd(OP_TAKE, 16'h0, 8'h0, 1'b0, 1'b0);
		send_cmd(OP_ADD, 16'h5555, 8'hAA, 1'b1, 1'b0);
		send_cmd(OP_TAKE, 16'h0, 8'h0, 1'b0, 1'b0);
		send_cmd(OP_REMOVE, 16'h0, 8'h00, 1'b0, 1'b0);
		send_cmd(OP_REMOVE, 16'hFFFF, 8'hAA, 1'b1, 1'b1);
		send_cmd(OP_CLEAR, 16'hFFFF, 8'hFF, 1'b1, 1'b1);
		send_cmd(OP_CLEAR, 16'h0, 8'h0, 1'b0, 1'b0);
		wait_drained();
	endtask

	// Fills the table past its depth so the drop status appears, then clears it.
	task automatic test_full_table();
		for (int i = 0; i < DEPTH + 3; i++)
			send_cmd(OP_ADD, 16'(i), 8'h80, 1'(i & 1), 1'b0);
		send_cmd(OP_ADD, 16'd3, 8'h80, 1'b1, 1'b1);
		send_cmd(OP_TAKE, 16'h0, 8'h0, 1'b0, 1'b0);
		send_cmd(OP_REMOVE, 16'h0, 8'h80, 1'b0, 1'b0);
		wait_drained();
	endtask

	// The receiver stops while the sender keeps offering words.
	task automatic test_receiver_hold_off();
		hold_off_cycles = 300;
		for (int i = 0; i < 20; i++)
			send_cmd(op_t'($urandom_range(0, 1)), 16'($urandom), 8'($urandom_range(1, 4)),
				1'($urandom), 1'($urandom));
		wait_drained();
	endtask

	task automatic test_random_traffic(int words);
		cmd_word_t c;
		int        roll;
		for (int i = 0; i < words; i++) begin
			roll = $urandom_range(0, 99);
			c = cmd_word_t'(IN_W'($urandom));
			// Small key pools make updates and multi-job removes frequent.
			if (roll < 50) begin
				c.op = OP_ADD;
				if ($urandom_range(0, 3) != 0) begin
					c.entry = 16'($urandom_range(0, 7));
					c.listener = 8'($urandom_range(1, 5));
				end
			end else if (roll < 85) begin
				c.op = OP_TAKE;
			end else if (roll < 96) begin
				c.op = OP_REMOVE;
				if ($urandom_range(0, 2) != 0) c.listener = 8'($urandom_range(0, 5));
			end else begin
				c.op = OP_CLEAR;
			end
			if (i % 200 < 20) stall_enable = 1'b0;
			else stall_enable = 1'b1;
			send_word(c, (i % 200 < 20) ? 0 : $urandom_range(0, 8));
			if (i % 300 == 150) wait_drained();
		end
		stall_enable = 1'b1;
		wait_drained();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_full_table();
		test_receiver_hold_off();
		test_random_traffic(1570);
		repeat (100) @(posedge clk);
		$display("Sent %0d words, checked %0d replies (%0d dispatches, %0d drops).",
			words_sent, replies_seen, count_taken, count_full);
		if (failures == 0 && pending_replies.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#(12 * 600000);
		$display("Regression FAIL");
		$finish;
	end
endmodule
